FILE: hw/rtl/cast_pkg.sv
package cast_pkg;

    // field widths of the request and result channels
    localparam int unsigned SEG_W  = 8;
    localparam int unsigned POS_W  = 3;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 8;
    localparam int unsigned MAP_W  = 24;
    localparam int unsigned IDX_W  = 4;

    // configuration port
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;
    localparam logic [MAP_W-1:0] MAP_RESET = 24'hFAC688;

    // low part of a column goes to the even ram address
    localparam logic [DATA_W-1:0] LOW_MASK = 8'h1F;

    // register index as decoded from paddr[2]
    typedef enum logic {
        REG_MAP_ENABLE  = 1'b0,
        REG_SEGMENT_MAP = 1'b1
    } t_reg_idx;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic             store;
        logic             load_out;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic pos_ok;
    } t_dp_stat;

endpackage

FILE: hw/rtl/cast_ifs.sv
interface cast_in_if;
    logic                         valid;
    logic                         ready;
    logic [cast_pkg::SEG_W-1:0]   segment_bits;
    logic [cast_pkg::POS_W-1:0]   digit_position;

    modport source (output valid, output segment_bits, output digit_position, input ready);
    modport sink   (input valid, input segment_bits, input digit_position, output ready);
endinterface

interface cast_out_if;
    logic                         valid;
    logic                         ready;
    logic [cast_pkg::ADDR_W-1:0]  ram_address;
    logic [cast_pkg::DATA_W-1:0]  ram_data;
    logic                         last_write;

    modport source (output valid, output ram_address, output ram_data, output last_write,
                    input ready);
    modport sink   (input valid, input ram_address, input ram_data, input last_write,
                    output ready);
endinterface

FILE: hw/rtl/common_anode_segment_transposer.sv
// common anode segment transposer
// i_in carries one digit request: segment_bits and digit_position. o_out carries
// display ram writes: ram_address, ram_data and last_write on the final write.
// A request with digit_position below POSITIONS updates that digit's stored byte
// (remapped through segment_map when map_enable is set) and then produces
// 2*SEGMENTS writes, two per segment line, in address order. A request at or
// beyond POSITIONS is taken and dropped with no writes.
// The first write is loaded into the output register from ST_EMIT, the state
// entered once the request is taken. Throughput: one write per cycle from the
// single output register while the receiver does not stall; a new request is
// taken once the last write is loaded, even while it still waits in the
// output register.
// A stalled receiver holds the output register and pauses the write sequence.
// Reset clears the stored digit bytes, map_enable, and loads the identity map.
// Registers: map_enable at byte address 0, segment_map at byte address 4;
// write only while no request is in flight.
module common_anode_segment_transposer #(
    parameter int unsigned POSITIONS = 5,
    parameter int unsigned SEGMENTS  = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cast_in_if.sink                       i_in,
    cast_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cast_pkg::APB_AW-1:0]   paddr,
    input  logic [cast_pkg::APB_DW-1:0]   pwdata,
    output logic [cast_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    cast_pkg::t_dp_cmd  cmd;
    cast_pkg::t_dp_stat stat;
    logic               cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    cast_ctrl #(
        .SEGMENTS (SEGMENTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cast_dp #(
        .POSITIONS (POSITIONS),
        .SEGMENTS  (SEGMENTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_addr       (paddr),
        .i_cfg_wdata      (pwdata),
        .o_cfg_rdata      (prdata),
        .i_segment_bits   (i_in.segment_bits),
        .i_digit_position (i_in.digit_position),
        .o_ram_address    (o_out.ram_address),
        .o_ram_data       (o_out.ram_data),
        .o_last_write     (o_out.last_write),
        .i_cmd            (cmd),
        .o_stat           (stat)
    );

endmodule

FILE: hw/rtl/cast_ctrl.sv
module cast_ctrl #(
    parameter int unsigned SEGMENTS = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  cast_pkg::t_dp_stat i_stat,
    output cast_pkg::t_dp_cmd  o_cmd
);

    localparam logic [cast_pkg::IDX_W-1:0] LAST_IDX = cast_pkg::IDX_W'(2 * SEGMENTS - 1);

    cast_pkg::t_state               r_state, n_state;
    logic [cast_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic                           r_out_valid, n_out_valid;
    logic                           in_fire;
    logic                           load;

    // state, write index and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cast_pkg::ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        load        = 1'b0;
        in_fire     = 1'b0;
        o_in_ready  = 1'b0;

        // a taken result empties the output register
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            cast_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                in_fire    = i_in_valid;
                if (i_in_valid && i_stat.pos_ok) begin
                    n_state = cast_pkg::ST_EMIT;
                    n_idx   = '0;
                end
            end
            cast_pkg::ST_EMIT: begin
                load = !r_out_valid || i_out_ready;
                if (load) begin
                    n_out_valid = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_state = cast_pkg::ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = cast_pkg::ST_IDLE;
            end
        endcase

        o_cmd.store    = in_fire && i_stat.pos_ok;
        o_cmd.load_out = load;
        o_cmd.idx      = r_idx;
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/cast_dp.sv
module cast_dp #(
    parameter int unsigned POSITIONS = 5,
    parameter int unsigned SEGMENTS  = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [cast_pkg::APB_AW-1:0]   i_cfg_addr,
    input  logic [cast_pkg::APB_DW-1:0]   i_cfg_wdata,
    output logic [cast_pkg::APB_DW-1:0]   o_cfg_rdata,
    // request payload
    input  logic [cast_pkg::SEG_W-1:0]    i_segment_bits,
    input  logic [cast_pkg::POS_W-1:0]    i_digit_position,
    // result payload
    output logic [cast_pkg::ADDR_W-1:0]   o_ram_address,
    output logic [cast_pkg::DATA_W-1:0]   o_ram_data,
    output logic                          o_last_write,
    // control
    input  cast_pkg::t_dp_cmd             i_cmd,
    output cast_pkg::t_dp_stat            o_stat
);

    localparam logic [cast_pkg::IDX_W-1:0] LAST_IDX = cast_pkg::IDX_W'(2 * SEGMENTS - 1);

    logic                           r_map_enable;
    logic [cast_pkg::MAP_W-1:0]     r_segment_map;
    logic [cast_pkg::SEG_W-1:0]     r_digit_bitmap [POSITIONS];
    logic [cast_pkg::ADDR_W-1:0]    r_ram_address;
    logic [cast_pkg::DATA_W-1:0]    r_ram_data;
    logic                           r_last_write;

    logic [cast_pkg::SEG_W-1:0]     remapped;
    logic [cast_pkg::SEG_W-1:0]     column;
    logic [2:0]                     seg_sel;
    logic [cast_pkg::DATA_W-1:0]    wr_data;
    cast_pkg::t_reg_idx             reg_sel;

    assign reg_sel = cast_pkg::t_reg_idx'(i_cfg_addr[2]);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_enable  <= 1'b0;
            r_segment_map <= cast_pkg::MAP_RESET;
        end else if (i_cfg_we) begin
            case (reg_sel)
                cast_pkg::REG_MAP_ENABLE:  r_map_enable  <= i_cfg_wdata[0];
                cast_pkg::REG_SEGMENT_MAP: r_segment_map <= i_cfg_wdata[cast_pkg::MAP_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            cast_pkg::REG_MAP_ENABLE:
                o_cfg_rdata = {{(cast_pkg::APB_DW-1){1'b0}}, r_map_enable};
            cast_pkg::REG_SEGMENT_MAP:
                o_cfg_rdata = {{(cast_pkg::APB_DW-cast_pkg::MAP_W){1'b0}}, r_segment_map};
            default:
                o_cfg_rdata = '0;
        endcase
    end

    // segment remap, colliding targets are ored
    always_comb begin
        if (!r_map_enable) begin
            remapped = i_segment_bits;
        end else begin
            remapped = '0;
            for (int n = 0; n < SEGMENTS; n++) begin
                if (i_segment_bits[n]) begin
                    remapped[r_segment_map[3*n +: 3]] = 1'b1;
                end
            end
        end
    end

    assign o_stat.pos_ok = ({1'b0, i_digit_position} < 4'(POSITIONS));

    // per-digit bitmap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < POSITIONS; p++) begin
                r_digit_bitmap[p] <= '0;
            end
        end else if (i_cmd.store) begin
            for (int p = 0; p < POSITIONS; p++) begin
                if (i_digit_position == cast_pkg::POS_W'(p)) begin
                    r_digit_bitmap[p] <= remapped;
                end
            end
        end
    end

    // column gather for the selected segment line
    assign seg_sel = i_cmd.idx[3:1];

    always_comb begin
        column = '0;
        for (int p = 0; p < POSITIONS; p++) begin
            column[p] = r_digit_bitmap[p][seg_sel];
        end
    end

    // even address gets low five digits, odd address the rest shifted down by two
    assign wr_data = i_cmd.idx[0] ? {2'b00, column[7:5], 3'b000}
                                  : (column & cast_pkg::LOW_MASK);

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_ram_address <= i_cmd.idx;
            r_ram_data    <= wr_data;
            r_last_write  <= (i_cmd.idx == LAST_IDX);
        end
    end

    assign o_ram_address = r_ram_address;
    assign o_ram_data    = r_ram_data;
    assign o_last_write  = r_last_write;

endmodule
